// ----- rtl/page_framebuffer_plotter_defines.svh -----
`ifndef PAGE_FRAMEBUFFER_PLOTTER_DEFINES_SVH
`define PAGE_FRAMEBUFFER_PLOTTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PFB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfb check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define PFB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfb check failed");

`endif

// ----- rtl/pfb_pkg.sv -----
package pfb_pkg;

	// command codes
	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_GLYPH = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// pixel rows held by one store byte
	localparam int PAGE_ROWS = 8;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] x;
		logic [5:0] y;
		logic [7:0] pattern;
		logic       color;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       clipped;
	} rsp_t;

endpackage

// ----- rtl/pfb_store.sv -----
module pfb_store #(
	parameter int DEPTH = 512,
	parameter int AW = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	// single port byte memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/page_framebuffer_plotter.sv -----
// After reset the store is swept to zero, one byte a cycle, before the first word is taken;
// the clear command runs the same sweep and then returns a result word.
// Pixel set and byte read: bounds check, the memory step when on screen, then the result.
// Glyph row: each of the 8 columns is stepped in turn, plus one read-modify-write step per
// lit on-screen pixel, as the store has a single memory port; one command is worked at a time.
// Reset (arst_n low) empties the result register and restarts the clearing sweep.
module page_framebuffer_plotter import pfb_pkg::*; #(
	parameter int SCREEN_WIDTH = 128,
	parameter int PAGE_COUNT = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int DEPTH = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROWS = PAGE_ROWS * PAGE_COUNT;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_STEP = 3'd1;
	localparam logic [2:0] ST_MOD  = 3'd2;
	localparam logic [2:0] ST_CLR  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    bit_q;
	logic [AW-1:0] sweep_q;
	logic          clr_item_q;
	logic          rsp_valid_q;

	logic [1:0]    mode_q;
	logic [8:0]    col_q;
	logic [5:0]    row_q;
	logic [7:0]    pat_q;
	logic          color_q;
	logic          clip_q;
	logic [7:0]    rd_byte_q;
	rsp_t          rsp_q;

	logic          on_screen;
	logic          pix_active;
	logic          last_bit;
	logic          rsp_free;
	logic [7:0]    mask;
	logic [AW-1:0] addr_calc;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;

	// shared address unit: bounds check and byte index of the current pixel
	assign on_screen = (col_q < 9'(SCREEN_WIDTH)) && ({1'b0, row_q} < 7'(ROWS));
	assign addr_calc = AW'(32'(col_q) + 32'(row_q[5:3]) * 32'(SCREEN_WIDTH));
	assign mask      = 8'd1 << row_q[2:0];

	// which column of the glyph row is being worked
	assign pix_active = (mode_q == MODE_GLYPH) ? pat_q[3'd7 - bit_q] : 1'b1;
	assign last_bit   = (mode_q != MODE_GLYPH) || (bit_q == 3'd7);

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != ST_IDLE);

	// memory port: sweep address while clearing, pixel address otherwise
	assign mem_addr = (state_q == ST_CLR) ? sweep_q : addr_calc;
	assign mem_we   = (state_q == ST_CLR) || ((state_q == ST_MOD) && (mode_q != MODE_READ));
	always_comb begin
		if (state_q == ST_CLR) begin
			mem_wdata = 8'd0;
		end else if ((mode_q == MODE_PIXEL) && !color_q) begin
			mem_wdata = mem_rdata & ~mask;
		end else begin
			mem_wdata = mem_rdata | mask;
		end
	end

	pfb_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			bit_q      <= 3'd0;
			sweep_q    <= '0;
			clr_item_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						bit_q <= 3'd0;
						if (cmd.mode == MODE_CLEAR) begin
							sweep_q    <= '0;
							clr_item_q <= 1'b1;
							state_q    <= ST_CLR;
						end else begin
							state_q <= ST_STEP;
						end
					end
				end
				ST_STEP: begin
					if (pix_active && on_screen) begin
						state_q <= ST_MOD;
					end else if (last_bit) begin
						state_q <= ST_DONE;
					end else begin
						bit_q <= bit_q + 3'd1;
					end
				end
				ST_MOD: begin
					if (last_bit) begin
						state_q <= ST_DONE;
					end else begin
						bit_q   <= bit_q + 3'd1;
						state_q <= ST_STEP;
					end
				end
				ST_CLR: begin
					if (sweep_q == AW'(DEPTH - 1)) begin
						state_q <= clr_item_q ? ST_DONE : ST_IDLE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// command fields, column walk and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					mode_q    <= cmd.mode;
					col_q     <= {1'b0, cmd.x};
					row_q     <= cmd.y;
					pat_q     <= cmd.pattern;
					color_q   <= cmd.color;
					clip_q    <= 1'b0;
					rd_byte_q <= 8'd0;
				end
			end
			ST_STEP: begin
				if (pix_active && !on_screen) begin
					clip_q <= 1'b1;
				end
				if (!(pix_active && on_screen) && !last_bit) begin
					col_q <= col_q + 9'd1;
				end
			end
			ST_MOD: begin
				if (mode_q == MODE_READ) begin
					rd_byte_q <= mem_rdata;
				end
				if (!last_bit) begin
					col_q <= col_q + 9'd1;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					rsp_q.read_data <= rd_byte_q;
					rsp_q.clipped   <= clip_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/pfb_checker.sv -----
`include "page_framebuffer_plotter_defines.svh"

module pfb_checker import pfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled result word holds
	`PFB_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// the block is busy right after taking a command
	`PFB_ASSERT_NXT(a_busy_after_cmd, cmd_valid && !cmd_stall, cmd_stall)

	// a clipped result never carries read data
	`PFB_ASSERT_IMP(a_clip_no_data, rsp_valid && rsp.clipped, rsp.read_data == 8'd0)

endmodule

bind page_framebuffer_plotter pfb_checker u_pfb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp(rsp)
);

// ----- tb/page_framebuffer_plotter_test.sv -----
`timescale 1ns / 1ps

module page_framebuffer_plotter_test;
	import pfb_pkg::*;

	localparam int SCREEN_WIDTH = 128;
	localparam int PAGE_COUNT = 4;
	localparam int SCREEN_ROWS = PAGE_COUNT * PAGE_ROWS;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int RANDOM_WORDS = 1025;
	// covers a clear or the reset sweep, plus the longest gap and stall
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		cmd_t c;
		bit   fixed;
		rsp_t want;
	} plot_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// mirror of the frame store, one byte per column per page
	logic [7:0] pix_store [STORE_BYTES];
	rsp_t expected_rsp_q [$];
	plot_row_t plot_rows [$];
	int errors = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	page_framebuffer_plotter #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.PAGE_COUNT(PAGE_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle length: mostly none, some short, a few long
	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// write one pixel of the mirror, returns 1 when it falls off screen
	function automatic bit put_dot(int col, int row, bit lit);
		if (col >= SCREEN_WIDTH || row >= SCREEN_ROWS)
			return 1'b1;
		pix_store[col + (row / PAGE_ROWS) * SCREEN_WIDTH][row % PAGE_ROWS] = lit;
		return 1'b0;
	endfunction

	// apply one command to the mirror and work out its result word
	function automatic rsp_t plot_step(cmd_t c);
		rsp_t r;
		r = '0;
		case (c.mode)
			MODE_PIXEL: begin
				r.clipped = put_dot(int'(c.x), int'(c.y), c.color);
			end
			MODE_GLYPH: begin
				// bit 7 is the leftmost pixel, dark bits are skipped
				for (int w = 0; w < 8; w++)
					if (c.pattern[7 - w])
						r.clipped |= put_dot(int'(c.x) + w, int'(c.y), 1'b1);
			end
			MODE_CLEAR: begin
				foreach (pix_store[k])
					pix_store[k] = '0;
			end
			MODE_READ: begin
				if (c.x < SCREEN_WIDTH && c.y < SCREEN_ROWS)
					r.read_data = pix_store[c.x + (c.y / PAGE_ROWS) * SCREEN_WIDTH];
				else
					r.clipped = 1'b1;
			end
		endcase
		return r;
	endfunction

	task automatic add_row(logic [1:0] m, int x, int y, int pat, bit color, bit fixed,
		int rd, bit clp);
		plot_row_t row;
		row.c.mode = m;
		row.c.x = 8'(x);
		row.c.y = 6'(y);
		row.c.pattern = 8'(pat);
		row.c.color = color;
		row.fixed = fixed;
		row.want.read_data = 8'(rd);
		row.want.clipped = clp;
		plot_rows.push_back(row);
	endtask

	// present one word, wait for it to be taken, then record its result
	task automatic send_word(cmd_t c, bit fixed, rsp_t want);
		int gap;
		rsp_t predicted;
		gap = gap_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		predicted = plot_step(c);
		expected_rsp_q.push_back(fixed ? want : predicted);
	endtask

	// result side: check each accepted word, then pick the next stall
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		int n;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word read_data %02h clipped %0b",
					$time, rsp.read_data, rsp.clipped);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.read_data !== want.read_data) begin
					errors++;
					$display("%0t: read_data expected %02h got %02h",
						$time, want.read_data, rsp.read_data);
				end
				if (rsp.clipped !== want.clipped) begin
					errors++;
					$display("%0t: clipped expected %0b got %0b",
						$time, want.clipped, rsp.clipped);
				end
			end
		end
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			n = gap_len();
			rsp_stall <= (n > 0);
			if (n > 0)
				stall_left <= n - 1;
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("page_framebuffer_plotter test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		cmd_t c;
		rsp_t none;
		int r;
		logic [7:0] last_x;
		logic [5:0] last_y;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		none = '0;
		last_x = '0;
		last_y = '0;
		foreach (pix_store[k])
			pix_store[k] = '0;

		// directed: empty store, corners, off screen pixels and reads, glyph edges, clear
		add_row(MODE_READ, 0, 0, 0, 0, 1, 8'h00, 0);
		add_row(MODE_READ, 127, 31, 0, 0, 1, 8'h00, 0);
		add_row(MODE_PIXEL, 0, 0, 0, 1, 1, 8'h00, 0);
		add_row(MODE_READ, 0, 0, 0, 0, 1, 8'h01, 0);
		add_row(MODE_PIXEL, 127, 31, 0, 1, 1, 8'h00, 0);
		add_row(MODE_READ, 127, 31, 0, 0, 1, 8'h80, 0);
		add_row(MODE_PIXEL, 128, 0, 0, 1, 1, 8'h00, 1);
		add_row(MODE_PIXEL, 0, 32, 0, 1, 1, 8'h00, 1);
		add_row(MODE_PIXEL, 255, 63, 8'hff, 0, 1, 8'h00, 1);
		add_row(MODE_READ, 128, 0, 0, 0, 1, 8'h00, 1);
		add_row(MODE_READ, 0, 63, 0, 0, 1, 8'h00, 1);
		add_row(MODE_READ, 255, 63, 8'hff, 1, 1, 8'h00, 1);
		add_row(MODE_PIXEL, 0, 0, 0, 0, 1, 8'h00, 0);
		add_row(MODE_READ, 0, 0, 0, 0, 1, 8'h00, 0);
		add_row(MODE_GLYPH, 120, 5, 8'hff, 0, 1, 8'h00, 0);
		add_row(MODE_GLYPH, 124, 5, 8'hff, 1, 1, 8'h00, 1);
		add_row(MODE_GLYPH, 124, 6, 8'hf0, 1, 1, 8'h00, 0);
		add_row(MODE_GLYPH, 250, 10, 8'h00, 1, 1, 8'h00, 0);
		add_row(MODE_GLYPH, 0, 40, 8'h81, 0, 1, 8'h00, 1);
		add_row(MODE_READ, 124, 5, 0, 0, 0, 0, 0);
		add_row(MODE_GLYPH, 3, 17, 8'ha5, 0, 0, 0, 0);
		add_row(MODE_READ, 5, 17, 0, 0, 0, 0, 0);
		add_row(MODE_CLEAR, 77, 19, 8'h5a, 1, 1, 8'h00, 0);
		add_row(MODE_READ, 124, 5, 0, 0, 1, 8'h00, 0);
		add_row(MODE_READ, 3, 17, 0, 0, 1, 8'h00, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plot_rows[k])
			send_word(plot_rows[k].c, plot_rows[k].fixed, plot_rows[k].want);

		// random: mostly on screen, some off screen, glyphs near the right edge,
		// reads aimed at recent drawing, a rare clear
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			quiet = ((i / 128) % 4 == 2);
			c.pattern = 8'($urandom);
			c.color = 1'($urandom);
			r = $urandom_range(0, 99);
			if (r < 2)
				c.mode = MODE_CLEAR;
			else if (r < 36)
				c.mode = MODE_PIXEL;
			else if (r < 68)
				c.mode = MODE_GLYPH;
			else
				c.mode = MODE_READ;
			c.x = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
				$urandom_range(0, SCREEN_WIDTH - 1));
			c.y = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) :
				$urandom_range(0, SCREEN_ROWS - 1));
			if (c.mode == MODE_GLYPH && $urandom_range(0, 3) == 0)
				c.x = 8'($urandom_range(SCREEN_WIDTH - 8, SCREEN_WIDTH + 4));
			if (c.mode == MODE_READ && $urandom_range(0, 2) == 0) begin
				c.x = 8'(last_x + $urandom_range(0, 7));
				c.y = last_y;
			end
			if (c.mode == MODE_PIXEL || c.mode == MODE_GLYPH) begin
				last_x = c.x;
				last_y = c.y;
			end
			send_word(c, 1'b0, none);
		end
		quiet = 1'b0;
		cmd_valid <= 1'b0;

		// drain the outstanding results, then watch for strays
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("page_framebuffer_plotter test passed");
		else
			$display("page_framebuffer_plotter test failed");
		$finish;
	end

endmodule

// ----- page_framebuffer_plotter.f -----
+incdir+rtl
rtl/pfb_pkg.sv
rtl/pfb_store.sv
rtl/page_framebuffer_plotter.sv
rtl/pfb_checker.sv
tb/page_framebuffer_plotter_test.sv
